// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the genotype AND-popcount table.
// Depends on nothing; the using module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define GAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GAC_ASSERT_NEVER(lbl, expr, msg) \
  `GAC_ASSERT(lbl, !(expr), msg)
`else
`define GAC_ASSERT(lbl, prop, msg)
`define GAC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/gac_pkg.sv -----
// Shared constants and the 64-bit population count for the genotype
// AND-popcount table. Depends on nothing.
`default_nettype none

package gac_pkg;

  localparam int unsigned GacMaxWords  = 1024;
  localparam int unsigned GacGenotypes = 3;

  localparam int unsigned WordW  = 64;
  localparam int unsigned SelW   = 2;
  localparam int unsigned PosW   = 10;
  localparam int unsigned WprW   = 11;
  localparam int unsigned RowW   = 16;
  localparam int unsigned CountW = 17;
  localparam int unsigned PopW   = 7;
  localparam int unsigned NumCountOut = 3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic {
    ReqLoad   = 1'b0,
    ReqStream = 1'b1
  } req_type_e;

  // Adder tree, one level per line, so the depth stays at six narrow adds.
  function automatic logic [PopW-1:0] popcount64(input logic [WordW-1:0] w);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = 2'(w[2*i]) + 2'(w[2*i+1]);
    for (int i = 0; i < 16; i++) l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
    for (int i = 0; i < 8; i++)  l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
    for (int i = 0; i < 4; i++)  l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
    for (int i = 0; i < 2; i++)  l5[i] = 6'(l4[2*i]) + 6'(l4[2*i+1]);
    return PopW'(l5[0]) + PopW'(l5[1]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gac_if.sv -----
// Valid/ready channel interfaces for the request and result transactions.
// Depends on gac_pkg for the field widths.
`default_nettype none

interface gac_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [gac_pkg::SelW-1:0]     genotype_select;
  logic [gac_pkg::PosW-1:0]     load_position;
  logic [gac_pkg::WordW-1:0]    word_data;

  modport source (output valid, req_type, genotype_select, load_position, word_data,
                  input ready);
  modport sink   (input valid, req_type, genotype_select, load_position, word_data,
                  output ready);
endinterface

interface gac_res_if;
  logic                         valid;
  logic                         ready;
  logic [gac_pkg::RowW-1:0]     row_number;
  logic [gac_pkg::CountW-1:0]   count_genotype0;
  logic [gac_pkg::CountW-1:0]   count_genotype1;
  logic [gac_pkg::CountW-1:0]   count_genotype2;

  modport source (output valid, row_number, count_genotype0, count_genotype1,
                  count_genotype2, input ready);
  modport sink   (input valid, row_number, count_genotype0, count_genotype1,
                  count_genotype2, output ready);
endinterface

`default_nettype wire

// ----- rtl/gac_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module gac_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/genotype_and_popcount_table.sv -----
// Genotype AND-popcount table: store of genotype rows plus a streaming
// accumulator. Depends on gac_pkg, gac_if, gac_ram and assert_macros.svh.
//
// Usage:
// - req_i carries request transactions. A load (req_type 0) writes word_data
//   into stored genotype row genotype_select at word load_position; loads
//   with an invalid row or position are dropped. A stream word (req_type 1)
//   is ANDed with the word at the current row position of every stored row,
//   and the ones of each AND add into one accumulator per genotype.
// - After words_per_row stream words, res_o delivers one result transaction
//   with the row number and the counts; the accumulators then clear.
// - cfg_we_i/cfg_wdata_i write words_per_row; write it only while idle.
// - Throughput: one request per cycle, loads and stream words alike, unless
//   a row end waits in stage 1 over a full output. The store is read through
//   one RAM bank per genotype, addressed by the word counter in the accept cycle.
// - Path: the RAM read and the stream word are registered into stage 1, then
//   popcount and accumulate write the output register at a row end.
// - Reset clears counters, accumulators and words_per_row (to 1). The store
//   is not cleared; read only words that have been loaded.
// - If the receiver stalls, one result waits in the output register; input
//   is still taken until a second row end reaches the accumulate stage.
`default_nettype none

module genotype_and_popcount_table #(
  parameter int unsigned MAX_WORDS = gac_pkg::GacMaxWords,
  parameter int unsigned GENOTYPES = gac_pkg::GacGenotypes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gac_pkg::WprW-1:0]  cfg_wdata_i,
  gac_req_if.sink                   req_i,
  gac_res_if.source                 res_o
);
  import gac_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WORDS);

  logic [WprW-1:0]   wpr_q;
  logic [AW-1:0]     word_cnt_q, word_cnt_d;
  logic [RowW-1:0]   row_q;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_last_q;
  logic [WordW-1:0]  s1_word_q;
  logic [CountW-1:0] acc_q [GENOTYPES];
  logic              out_valid_q, out_valid_d;
  logic [RowW-1:0]   out_row_q;
  logic [CountW-1:0] out_cnt_q [NumCountOut];

  logic              out_free, s1_go, s1_emit, in_ready, in_acc;
  logic              stream_acc, load_acc, sel_ok, pos_ok, row_end;
  logic [31:0]       len, cnt_ext, wpr_ext;
  logic [AW-1:0]     waddr;
  logic [WordW-1:0]  rdata [GENOTYPES];
  logic [CountW-1:0] sat [GENOTYPES];

  // Handshake: stage 1 only blocks when it holds a row end and the output is full.
  assign out_free = !out_valid_q || res_o.ready;
  assign s1_go    = s1_valid_q && (!s1_last_q || out_free);
  assign s1_emit  = s1_go && s1_last_q;
  assign in_ready = !s1_valid_q || s1_go;
  assign req_i.ready = in_ready;
  assign in_acc     = req_i.valid && in_ready;
  assign stream_acc = in_acc && (req_i.req_type == ReqStream);
  assign load_acc   = in_acc && (req_i.req_type == ReqLoad);

  assign sel_ok = 32'(req_i.genotype_select) < GENOTYPES;
  assign pos_ok = 32'(req_i.load_position) < MAX_WORDS;
  assign waddr  = AW'(32'(req_i.load_position));

  // Effective row length: zero acts as one, oversize values clamp.
  assign wpr_ext = 32'(wpr_q);
  assign cnt_ext = 32'(word_cnt_q);
  always_comb begin
    priority if (wpr_ext == 32'd0) begin
      len = 32'd1;
    end else if (wpr_ext > MAX_WORDS) begin
      len = MAX_WORDS;
    end else begin
      len = wpr_ext;
    end
  end
  assign row_end = (cnt_ext + 32'd1) >= len;

  always_comb begin
    word_cnt_d = word_cnt_q;
    if (stream_acc) begin
      word_cnt_d = row_end ? '0 : AW'(cnt_ext + 32'd1);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (stream_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  for (genvar g = 0; g < GENOTYPES; g++) begin : g_bank
    logic [CountW:0]   sum;
    logic [PopW-1:0]   pop;

    gac_ram #(
      .WIDTH (WordW),
      .DEPTH (MAX_WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (load_acc && sel_ok && pos_ok && (req_i.genotype_select == SelW'(g))),
      .waddr_i (waddr),
      .wdata_i (req_i.word_data),
      .re_i    (stream_acc),
      .raddr_i (word_cnt_q),
      .rdata_o (rdata[g])
    );

    assign pop    = popcount64(s1_word_q & rdata[g]);
    assign sum    = {1'b0, acc_q[g]} + (CountW+1)'(pop);
    assign sat[g] = sum[CountW] ? CountMax : sum[CountW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[g] <= '0;
      end else if (s1_go) begin
        acc_q[g] <= s1_last_q ? '0 : sat[g];
      end
    end
  end

  for (genvar j = 0; j < NumCountOut; j++) begin : g_out
    if (j < GENOTYPES) begin : g_used
      always_ff @(posedge clk_i) begin
        if (s1_emit) begin
          out_cnt_q[j] <= sat[j];
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk_i) begin
        if (s1_emit) begin
          out_cnt_q[j] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpr_q       <= WprW'(1);
      word_cnt_q  <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wpr_q <= cfg_wdata_i;
      end
      word_cnt_q  <= word_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_emit) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stream_acc) begin
      s1_word_q <= req_i.word_data;
      s1_last_q <= row_end;
    end
    if (s1_emit) begin
      out_row_q <= row_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.row_number      = out_row_q;
  assign res_o.count_genotype0 = out_cnt_q[0];
  assign res_o.count_genotype1 = out_cnt_q[1];
  assign res_o.count_genotype2 = out_cnt_q[2];

`include "assert_macros.svh"

  `GAC_ASSERT(a_cnt_range, (32'(word_cnt_q) < MAX_WORDS), "word counter out of range")
  `GAC_ASSERT(a_stall_blocks,
              (s1_valid_q && s1_last_q && out_valid_q && !res_o.ready) |-> !req_i.ready,
              "row end accepted over a full output")
  `GAC_ASSERT(a_stream_enters, stream_acc |=> s1_valid_q, "stream transaction lost before accumulate")
  `GAC_ASSERT(a_emit_shows, s1_emit |=> out_valid_q, "finished row not presented")

endmodule

`default_nettype wire
